// ===== hw/rtl/mtr_pkg.sv =====
`default_nettype none

package mtr_pkg;

   // Timestamp and configuration widths.
   localparam int TIME_W = 48;
   localparam int AVG_W  = 24;

   // Number of rising timestamps held for the average step. WINDOW_LEN - 1
   // must stay a power of two so that the average is a plain shift.
   localparam int WINDOW_LEN = 5;

   // Configuration port geometry: byte address 4*i for register i.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register indexes.
   localparam logic CSR_DEFAULT_AVG_STEP = 1'b0;

   // Reset value of the default average step, in microseconds.
   localparam logic [AVG_W-1:0] DEFAULT_AVG_STEP_RESET = AVG_W'(66000);

   // Operation codes carried by each input beat.
   typedef enum logic [1:0] {
      OP_FRAME  = 2'd0,
      OP_PAUSE  = 2'd1,
      OP_RESET  = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   // Unsigned add that clamps at the largest timestamp.
   function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
      logic [TIME_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/media_timestamp_rebaser_top.sv =====
`default_nettype none

// Media timestamp rebaser. Each req beat carries an operation: a frame
// timestamp (one rsp beat with the rebased play time and a flag for a
// backward-jump correction), a pause interval to subtract from later frames,
// or a timer reset (no rsp beat for either). An item is processed in the
// cycle it is accepted and its result is registered in the output register
// (or the skid register); one item is taken every cycle while req_stall is
// low. A skid register behind the output register absorbs one result while
// the rsp side stalls, so req_stall only rises once that skid register is
// occupied. The average frame step is taken from the last WINDOW_LEN rising
// timestamps, held in a shift line, and the window span is kept registered so
// the next frame only has to divide it by WINDOW_LEN - 1, a power of two,
// which reduces to a shift. Writing default_avg_step also loads the running
// average step; write it only while the block is idle.
module media_timestamp_rebaser_top
   import mtr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   // Input channel
   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire logic [1:0]            req_op,
   input  wire logic [TIME_W-1:0]     req_frame_time,
   input  wire logic [TIME_W-1:0]     req_pause_start,
   input  wire logic [TIME_W-1:0]     req_pause_end,

   // Result channel
   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      logic [TIME_W-1:0]     rsp_play_time,
   output      logic                  rsp_jump_corrected,

   // Configuration port
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output      logic [CSR_DATA_W-1:0] prdata,
   output      logic                  pready
);

   localparam int COUNT_W = $clog2(WINDOW_LEN + 1);
   localparam int AVG_DIV = WINDOW_LEN - 1;
   localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(WINDOW_LEN);

   // Timer state.
   logic [TIME_W-1:0]  window_ff [WINDOW_LEN];
   logic [COUNT_W-1:0] window_count_ff;
   logic [TIME_W-1:0]  window_span_ff;
   logic               window_rising_ff;
   logic [TIME_W-1:0]  last_time_ff;
   logic [TIME_W-1:0]  paused_total_ff;
   logic [TIME_W-1:0]  added_offset_ff;
   logic [TIME_W-1:0]  avg_step_ff;
   logic [AVG_W-1:0]   default_avg_step_ff;

   // Output register and skid register.
   logic               rsp_valid_ff;
   logic [TIME_W-1:0]  rsp_play_time_ff;
   logic               rsp_jump_ff;
   logic               skid_valid_ff;
   logic [TIME_W-1:0]  skid_play_time_ff;
   logic               skid_jump_ff;

   // Next-state values.
   logic               accept;
   logic               rsp_taken;
   logic               csr_write;
   logic               window_full;
   logic [TIME_W-1:0]  avg_quot;
   logic [TIME_W-1:0]  avg_step_in;
   logic               frame_rising;
   logic               frame_falling;
   logic [TIME_W-1:0]  jump_corr;
   logic [TIME_W-1:0]  added_offset_in;
   logic [TIME_W-1:0]  base_time;
   logic [TIME_W-1:0]  play_time_in;
   logic [COUNT_W-1:0] window_count_in;
   logic [TIME_W-1:0]  paused_total_in;
   logic               pause_ok;

   assign accept    = req_valid && !req_stall;
   assign rsp_taken = rsp_valid_ff && !rsp_stall;
   assign csr_write = psel && penable && pwrite && (paddr[2] == CSR_DEFAULT_AVG_STEP);

   assign req_stall          = skid_valid_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_play_time      = rsp_play_time_ff;
   assign rsp_jump_corrected = rsp_jump_ff;

   // Register reads: only the default average step exists.
   assign pready = 1'b1;
   assign prdata = (paddr[2] == CSR_DEFAULT_AVG_STEP) ?
                   {{(CSR_DATA_W - AVG_W){1'b0}}, default_avg_step_ff} : '0;

   // Frame path: refresh the average step from the full window, then apply a
   // backward-jump correction and rebase the timestamp.
   always_comb begin
      window_full   = (window_count_ff == COUNT_FULL);
      avg_quot      = window_span_ff / TIME_W'(AVG_DIV);
      avg_step_in   = (window_full && window_rising_ff && (avg_quot != '0)) ?
                      avg_quot : avg_step_ff;
      frame_rising  = (req_frame_time > last_time_ff);
      frame_falling = (req_frame_time < last_time_ff);

      jump_corr       = sat_add(last_time_ff - req_frame_time, avg_step_in);
      added_offset_in = frame_falling ? sat_add(added_offset_ff, jump_corr)
                                      : added_offset_ff;

      // A jump clears the paused total, so the timestamp passes unchanged; so does a timestamp below the paused total.
      if (frame_falling || (req_frame_time < paused_total_ff)) begin
         base_time = req_frame_time;
      end else begin
         base_time = req_frame_time - paused_total_ff;
      end
      play_time_in = sat_add(base_time, added_offset_in);

      if (frame_falling) begin
         window_count_in = '0;
      end else if (frame_rising && !window_full) begin
         window_count_in = window_count_ff + COUNT_W'(1);
      end else begin
         window_count_in = window_count_ff;
      end

      pause_ok        = (req_pause_start != '0) && (req_pause_start < req_pause_end);
      paused_total_in = sat_add(paused_total_ff, req_pause_end - req_pause_start);
   end

   // Timer state and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_count_ff     <= '0;
         last_time_ff        <= '0;
         paused_total_ff     <= '0;
         added_offset_ff     <= '0;
         avg_step_ff         <= TIME_W'(DEFAULT_AVG_STEP_RESET);
         default_avg_step_ff <= DEFAULT_AVG_STEP_RESET;
      end else begin
         if (accept) begin
            case (req_op)
               OP_FRAME: begin
                  avg_step_ff     <= avg_step_in;
                  added_offset_ff <= added_offset_in;
                  window_count_ff <= window_count_in;
                  last_time_ff    <= req_frame_time;
                  if (frame_falling) begin
                     paused_total_ff <= '0;
                  end
               end
               OP_PAUSE: begin
                  if (pause_ok) begin
                     paused_total_ff <= paused_total_in;
                  end
               end
               OP_RESET: begin
                  window_count_ff <= '0;
                  last_time_ff    <= '0;
                  paused_total_ff <= '0;
                  added_offset_ff <= '0;
               end
               default: begin
               end
            endcase
         end
         if (csr_write) begin
            default_avg_step_ff <= pwdata[AVG_W-1:0];
            avg_step_ff         <= TIME_W'(pwdata[AVG_W-1:0]);
         end
      end
   end

   // Window shift line; the span to the entry that becomes oldest is kept
   // ready for the next frame.
   always_ff @(posedge clock) begin
      if (accept && (req_op == OP_FRAME) && frame_rising) begin
         window_ff[0]     <= req_frame_time;
         for (int i = 1; i < WINDOW_LEN; i++) begin
            window_ff[i] <= window_ff[i-1];
         end
         window_span_ff   <= req_frame_time - window_ff[WINDOW_LEN-2];
         window_rising_ff <= (req_frame_time > window_ff[WINDOW_LEN-2]);
      end
   end

   // Output register with one skid entry behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (skid_valid_ff) begin
            if (rsp_taken) begin
               rsp_play_time_ff <= skid_play_time_ff;
               rsp_jump_ff      <= skid_jump_ff;
               skid_valid_ff    <= 1'b0;
            end
         end else if (accept && (req_op == OP_FRAME)) begin
            if (!rsp_valid_ff || rsp_taken) begin
               rsp_valid_ff     <= 1'b1;
               rsp_play_time_ff <= play_time_in;
               rsp_jump_ff      <= frame_falling;
            end else begin
               skid_valid_ff     <= 1'b1;
               skid_play_time_ff <= play_time_in;
               skid_jump_ff      <= frame_falling;
            end
         end else if (rsp_taken) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Checks on the block's own logic.
   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry held while output register is empty");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      window_count_ff <= COUNT_FULL)
      else $error("window count beyond window length");

   a_frame_gives_result: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_op == OP_FRAME)) |=> rsp_valid_ff)
      else $error("accepted frame produced no result");

   a_reset_op_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_op == OP_RESET)) |=>
         ((window_count_ff == '0) && (added_offset_ff == '0) && (paused_total_ff == '0)))
      else $error("timer reset left state behind");

   a_jump_empties_window: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_op == OP_FRAME) && frame_falling) |=>
         ((window_count_ff == '0) && (paused_total_ff == '0)))
      else $error("backward jump did not clear window and pause total");

endmodule

`default_nettype wire
